@@ src/flight_log_field_encoder_defines.svh @@
// Assertion macros for the flight log field encoder.
// Used by the top level only; no other dependencies.
`ifndef FLIGHT_LOG_FIELD_ENCODER_DEFINES_SVH
`define FLIGHT_LOG_FIELD_ENCODER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define FLE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define FLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ src/fle_pkg.sv @@
// Shared types and codes for the flight log field encoder.
// No dependencies.
`default_nettype none
package fle_pkg;
    typedef enum logic [2:0] {
        OP_UVARINT = 3'd0,
        OP_SVARINT = 3'd1,
        OP_S16     = 3'd2,
        OP_U32     = 3'd3,
        OP_TAG2X3  = 3'd4,
        OP_TAG8X4  = 3'd5,
        OP_BITMAP  = 3'd6,
        OP_NONE    = 3'd7
    } op_t;

    // Source kinds of a byte that the sequencer asks the datapath to produce.
    typedef enum logic [2:0] {
        BK_VARINT = 3'd0,  // next varint group of the working word
        BK_SHIFT  = 3'd1,  // low byte of working word, then shift right 8
        BK_CONST  = 3'd2,  // literal byte from the sequencer
        BK_NIBBLE = 3'd3   // nibble-stream byte
    } bkind_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] value0;
        logic [31:0] value1;
        logic [31:0] value2;
        logic [31:0] value3;
        logic [31:0] value4;
        logic [31:0] value5;
        logic [31:0] value6;
        logic [31:0] value7;
        logic [3:0]  field_count;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } rsp_t;

    localparam int unsigned MAX_BYTES = 41;

    function automatic logic [31:0] zigzag(input logic [31:0] v);
        zigzag = {v[30:0], 1'b0} ^ {32{v[31]}};
    endfunction

    // Two's complement range test: value fits signed in (bits) bits.
    function automatic logic fits8(input logic [31:0] v);
        fits8 = (v[31:7] == '0) || (v[31:7] == '1);
    endfunction
    function automatic logic fits16(input logic [31:0] v);
        fits16 = (v[31:15] == '0) || (v[31:15] == '1);
    endfunction
    function automatic logic fits24(input logic [31:0] v);
        fits24 = (v[31:23] == '0) || (v[31:23] == '1);
    endfunction
    function automatic logic fits4(input logic [31:0] v);
        fits4 = (v[31:3] == '0) || (v[31:3] == '1);
    endfunction
    function automatic logic fits6(input logic [31:0] v);
        fits6 = (v[31:5] == '0) || (v[31:5] == '1);
    endfunction
    function automatic logic fits2(input logic [31:0] v);
        fits2 = (v[31:1] == '0) || (v[31:1] == '1);
    endfunction
endpackage
`default_nettype wire

@@ src/fle_stream_if.sv @@
// Valid/ready channel carrying one payload of type T.
// Depends on nothing; payload types come from fle_pkg.
`default_nettype none
interface fle_stream_if #(parameter type T = logic) (input wire logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/flight_log_field_encoder.sv @@
// Flight log field encoder: takes one encode request and sends its log bytes,
// one transfer per byte, on the output channel, with last_byte on the final
// byte. The request is accepted in the idle state; S_HEAD then decodes it and
// presents the header byte where the mode has one. Each walked field is planned
// in S_LOAD, which loads the shared byte unit, and is then sent in S_EMIT one
// byte per step (one nibble per step in the four-field packing); an odd nibble
// count adds the S_PAD state, and S_DONE hands over the last byte. Output stalls
// hold the byte steps. The single shared byte unit serializes every field. The
// block takes no new request until the last byte of the current one has been
// transferred.
`default_nettype none
`include "flight_log_field_encoder_defines.svh"
module flight_log_field_encoder
    import fle_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    fle_stream_if.sink   req,
    fle_stream_if.source rsp
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_HEAD  = 6'b000010,
        S_LOAD  = 6'b000100,
        S_EMIT  = 6'b001000,
        S_PAD   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    // Per-field plan: how the current field is sent
    typedef enum logic [2:0] {
        FM_VARINT = 3'd0,  // varint of working word
        FM_BYTES  = 3'd1,  // n little-endian bytes
        FM_NIB    = 3'd2,  // n nibbles into the nibble stream
        FM_SKIP   = 3'd3
    } fmode_t;

    state_t      state_reg, state_next;
    req_t        r_reg;
    logic [3:0]  idx_reg, idx_next;       // field index
    logic [3:0]  lf_reg, lf_next;         // index of the last field that sends bytes
    logic [2:0]  cnt_reg, cnt_next;       // units left in current field
    fmode_t      fm_reg, fm_next;
    logic        half_reg, half_next;     // nibble pending
    logic [3:0]  hold_reg, hold_next;
    logic [7:0]  ob_reg, ob_next;
    logic        ol_reg, ol_next;
    logic        ov_reg, ov_next;
    logic [3:0]  cnt8;
    logic [7:0]  bmh;
    logic [7:0]  c84m;
    logic [1:0]  bcur, ncur;
    logic        fin;

    logic [1:0]  tag2;
    logic [5:0]  c23;
    logic [7:0]  c84;
    logic        load, step, more;
    logic [31:0] load_word, word;
    bkind_t      kind;
    logic [7:0]  const_byte, ub;
    logic [31:0] fv;

    // Highest set bit of a field mask
    function automatic logic [3:0] top_index(input logic [7:0] m);
        top_index = 4'd0;
        for (int i = 0; i < 8; i++)
            if (m[i]) top_index = 4'(i);
    endfunction

    fle_class u_class (
        .v0(r_reg.value0), .v1(r_reg.value1), .v2(r_reg.value2), .v3(r_reg.value3),
        .tag2(tag2), .cls2x3(c23), .cls8x4(c84)
    );

    fle_byte_unit u_byte (
        .clk(clk), .load(load), .load_word(load_word), .step(step), .kind(kind),
        .const_byte(const_byte), .hold_nib(hold_reg), .byte_out(ub), .more(more),
        .word(word)
    );

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = ov_reg;
    assign rsp.data     = '{out_byte: ob_reg, last_byte: ol_reg};
    assign cnt8 = (r_reg.field_count > 4'd8) ? 4'd8 : r_reg.field_count;

    // Bitmap header: nonzero fields among the first cnt8
    assign bmh = {r_reg.value7 != '0, r_reg.value6 != '0, r_reg.value5 != '0,
                  r_reg.value4 != '0, r_reg.value3 != '0, r_reg.value2 != '0,
                  r_reg.value1 != '0, r_reg.value0 != '0} & ~(8'hFF << cnt8);

    // Four-field packing: fields that carry nibbles
    assign c84m = {4'd0, c84[7:6] != 2'd0, c84[5:4] != 2'd0, c84[3:2] != 2'd0,
                   c84[1:0] != 2'd0};

    // Field value mux by index
    always_comb
    begin
        case (idx_reg[2:0])
            3'd0:    fv = r_reg.value0;
            3'd1:    fv = r_reg.value1;
            3'd2:    fv = r_reg.value2;
            3'd3:    fv = r_reg.value3;
            3'd4:    fv = r_reg.value4;
            3'd5:    fv = r_reg.value5;
            3'd6:    fv = r_reg.value6;
            default: fv = r_reg.value7;
        endcase
    end

    // Size classes of the current field
    always_comb
    begin
        case (idx_reg[1:0])
            2'd0:    bcur = c23[1:0];
            2'd1:    bcur = c23[3:2];
            default: bcur = c23[5:4];
        endcase
        case (idx_reg[1:0])
            2'd0:    ncur = c84[1:0];
            2'd1:    ncur = c84[3:2];
            2'd2:    ncur = c84[5:4];
            default: ncur = c84[7:6];
        endcase
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            r_reg <= req.data;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        lf_next    = lf_reg;
        cnt_next   = cnt_reg;
        fm_next    = fm_reg;
        half_next  = half_reg;
        hold_next  = hold_reg;
        ob_next    = ob_reg;
        ol_next    = ol_reg;
        ov_next    = ov_reg;
        load       = 1'b0;
        load_word  = fv;
        step       = 1'b0;
        kind       = BK_CONST;
        const_byte = 8'h00;
        fin        = 1'b0;
        if (ov_reg && rsp.ready)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                half_next = 1'b0;
                if (req.valid)
                    state_next = S_HEAD;
            end
            S_HEAD:
            begin
                // Emit header byte where the mode has one, else start field 0
                state_next = S_LOAD;
                idx_next   = '0;
                lf_next    = '0;
                case (op_t'(r_reg.operation))
                    OP_TAG2X3:
                    begin
                        ov_next = 1'b1;
                        ol_next = 1'b0;
                        lf_next = 4'd2;
                        unique case (tag2)
                            2'd0:
                            begin
                                ob_next = {2'b00, r_reg.value0[1:0], r_reg.value1[1:0],
                                           r_reg.value2[1:0]};
                                ol_next = 1'b1;
                                state_next = S_DONE;
                            end
                            2'd1:
                            begin
                                ob_next = {2'b01, 2'b00, r_reg.value0[3:0]};
                                idx_next = 4'd8;
                                lf_next = 4'd8;
                            end
                            2'd2:
                            begin
                                ob_next = {2'b10, r_reg.value0[5:0]};
                                idx_next = 4'd1;
                            end
                            default:
                            begin
                                ob_next = {2'b11, c23};
                            end
                        endcase
                    end
                    OP_TAG8X4:
                    begin
                        ob_next = c84;
                        ol_next = (c84 == 8'h00);
                        ov_next = 1'b1;
                        lf_next = top_index(c84m);
                        state_next = (c84 == 8'h00) ? S_DONE : S_LOAD;
                    end
                    OP_BITMAP:
                    begin
                        if (cnt8 == 4'd0)
                            state_next = S_IDLE;
                        else if (cnt8 != 4'd1)
                        begin
                            ob_next = bmh;
                            ol_next = (bmh == 8'h00);
                            ov_next = 1'b1;
                            lf_next = top_index(bmh);
                            state_next = (bmh == 8'h00) ? S_DONE : S_LOAD;
                        end
                    end
                    OP_NONE:  state_next = S_IDLE;
                    default: ;
                endcase
            end
            S_LOAD:
            begin
                // Plan the current field and load the byte unit
                load = 1'b1;
                fm_next = FM_SKIP;
                cnt_next = 3'd0;
                case (op_t'(r_reg.operation))
                    OP_UVARINT: fm_next = FM_VARINT;
                    OP_SVARINT:
                    begin
                        fm_next = FM_VARINT;
                        load_word = zigzag(fv);
                    end
                    OP_S16:
                    begin
                        fm_next = FM_BYTES;
                        cnt_next = 3'd2;
                    end
                    OP_U32:
                    begin
                        fm_next = FM_BYTES;
                        cnt_next = 3'd4;
                    end
                    OP_TAG2X3:
                    begin
                        fm_next = FM_BYTES;
                        if (idx_reg == 4'd8)
                        begin
                            // Second byte of the 4-bit packing: two nibbles
                            cnt_next = 3'd1;
                            load_word = {24'd0, r_reg.value1[3:0], r_reg.value2[3:0]};
                        end
                        else if (tag2 == 2'd2)
                            cnt_next = 3'd1;
                        else
                            cnt_next = {1'b0, bcur} + 3'd1;
                    end
                    OP_TAG8X4:
                    begin
                        // Left-align the nibbles of this field
                        case (ncur)
                            2'd1:
                            begin
                                fm_next = FM_NIB;
                                cnt_next = 3'd1;
                                load_word = {fv[3:0], 28'd0};
                            end
                            2'd2:
                            begin
                                fm_next = FM_NIB;
                                cnt_next = 3'd2;
                                load_word = {fv[7:0], 24'd0};
                            end
                            2'd3:
                            begin
                                fm_next = FM_NIB;
                                cnt_next = 3'd4;
                                load_word = {fv[15:0], 16'd0};
                            end
                            default: ;
                        endcase
                    end
                    OP_BITMAP:
                    begin
                        fm_next = (fv != '0 || cnt8 == 4'd1) ? FM_VARINT : FM_SKIP;
                        load_word = zigzag(fv);
                    end
                    default: ;
                endcase
                // Skip fields that send nothing
                if (fm_next != FM_SKIP)
                    state_next = S_EMIT;
                else if (idx_reg >= lf_reg)
                    state_next = S_DONE;
                else
                    idx_next = idx_reg + 4'd1;
            end
            S_EMIT:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ol_next = 1'b0;
                    unique case (fm_reg)
                        FM_VARINT:
                        begin
                            kind = BK_VARINT;
                            step = 1'b1;
                            ob_next = ub;
                            ov_next = 1'b1;
                            fin = !more;
                        end
                        FM_BYTES:
                        begin
                            kind = BK_SHIFT;
                            step = 1'b1;
                            ob_next = ub;
                            ov_next = 1'b1;
                            cnt_next = cnt_reg - 3'd1;
                            fin = (cnt_reg == 3'd1);
                        end
                        FM_NIB:
                        begin
                            kind = BK_NIBBLE;
                            step = 1'b1;
                            cnt_next = cnt_reg - 3'd1;
                            fin = (cnt_reg == 3'd1);
                            if (half_reg)
                            begin
                                ob_next = ub;
                                ov_next = 1'b1;
                                half_next = 1'b0;
                            end
                            else
                            begin
                                // Hold the top nibble for the next byte
                                hold_next = word[31:28];
                                half_next = 1'b1;
                            end
                        end
                        default: fin = 1'b1;
                    endcase
                    // Advance to the next field, or close the request
                    if (fin)
                    begin
                        if (idx_reg == lf_reg)
                        begin
                            if (half_next)
                                state_next = S_PAD;
                            else
                            begin
                                ol_next = 1'b1;
                                state_next = S_DONE;
                            end
                        end
                        else
                        begin
                            idx_next = idx_reg + 4'd1;
                            state_next = S_LOAD;
                        end
                    end
                end
            end
            S_PAD:
            begin
                // Close an odd nibble count with a zero nibble
                if (!ov_reg || rsp.ready)
                begin
                    ob_next = {hold_reg, 4'd0};
                    ov_next = 1'b1;
                    ol_next = 1'b1;
                    half_next = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || rsp.ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            idx_reg   <= '0;
            lf_reg    <= '0;
            cnt_reg   <= '0;
            fm_reg    <= FM_SKIP;
            half_reg  <= 1'b0;
            hold_reg  <= '0;
            ob_reg    <= '0;
            ol_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            idx_reg   <= idx_next;
            lf_reg    <= lf_next;
            cnt_reg   <= cnt_next;
            fm_reg    <= fm_next;
            half_reg  <= half_next;
            hold_reg  <= hold_next;
            ob_reg    <= ob_next;
            ol_reg    <= ol_next;
        end
    end

    `FLE_ASSERT_IMPL(a_no_accept_busy, state_reg != S_IDLE, !req.ready, "accepted while busy")
    `FLE_ASSERT_NEXT(a_hold_stall, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.data),
        "output changed under stall")
    `FLE_ASSERT_IMPL(a_idle_empty, state_reg == S_IDLE, !rsp.valid, "byte pending in idle")
endmodule
`default_nettype wire

@@ src/fle_class.sv @@
// Per-field size classes and header bytes for the tagged packings.
// Depends on fle_pkg.
`default_nettype none
module fle_class
    import fle_pkg::*;
(
    input  wire logic [31:0] v0,
    input  wire logic [31:0] v1,
    input  wire logic [31:0] v2,
    input  wire logic [31:0] v3,
    output logic [1:0]       tag2,
    output logic [5:0]       cls2x3,
    output logic [7:0]       cls8x4
);
    logic [1:0] t0, t1, t2;

    // Tag of the three-field packing: widest need wins
    function automatic logic [1:0] need(input logic [31:0] v);
        if (!fits6(v))      need = 2'd3;
        else if (!fits4(v)) need = 2'd2;
        else if (!fits2(v)) need = 2'd1;
        else                need = 2'd0;
    endfunction

    function automatic logic [1:0] bcls(input logic [31:0] v);
        if (fits8(v))       bcls = 2'd0;
        else if (fits16(v)) bcls = 2'd1;
        else if (fits24(v)) bcls = 2'd2;
        else                bcls = 2'd3;
    endfunction

    function automatic logic [1:0] ncls(input logic [31:0] v);
        if (v == '0)        ncls = 2'd0;
        else if (fits4(v))  ncls = 2'd1;
        else if (fits8(v))  ncls = 2'd2;
        else                ncls = 2'd3;
    endfunction

    always_comb
    begin
        t0 = need(v0);
        t1 = need(v1);
        t2 = need(v2);
        tag2 = t0;
        if (t1 > tag2) tag2 = t1;
        if (t2 > tag2) tag2 = t2;
        cls2x3 = {bcls(v2), bcls(v1), bcls(v0)};
        cls8x4 = {ncls(v3), ncls(v2), ncls(v1), ncls(v0)};
    end
endmodule
`default_nettype wire

@@ src/fle_byte_unit.sv @@
// Shared byte unit: produces one output byte a cycle while stepped, from a working word.
// Depends on fle_pkg.
`default_nettype none
module fle_byte_unit
    import fle_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        load,
    input  wire logic [31:0] load_word,
    input  wire logic        step,
    input  wire bkind_t      kind,
    input  wire logic [7:0]  const_byte,
    input  wire logic [3:0]  hold_nib,
    output logic [7:0]       byte_out,
    output logic             more,
    output logic [31:0]      word
);
    logic [31:0] word_reg, word_next;

    assign word = word_reg;
    // Varint continues while the remaining word exceeds 7 bits
    assign more = (word_reg[31:7] != '0);

    always_comb
    begin
        byte_out  = 8'h00;
        word_next = word_reg;
        case (kind)
            BK_VARINT:
            begin
                byte_out  = {more, word_reg[6:0]};
                word_next = {7'd0, word_reg[31:7]};
            end
            BK_SHIFT:
            begin
                byte_out  = word_reg[7:0];
                word_next = {8'd0, word_reg[31:8]};
            end
            BK_NIBBLE:
            begin
                // Held nibble on top, next nibble of the left-aligned word below
                byte_out  = {hold_nib, word_reg[31:28]};
                word_next = {word_reg[27:0], 4'd0};
            end
            default:
            begin
                byte_out = const_byte;
            end
        endcase
        if (load)
            word_next = load_word;
        else if (!step)
            word_next = word_reg;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end
endmodule
`default_nettype wire

@@ verif/flight_log_field_encoder_tb.sv @@
// Self-checking testbench for the flight log field encoder: encode requests in,
// log bytes out, each byte compared against an in-bench byte-stream predictor.
// Depends on fle_pkg, fle_stream_if and the flight_log_field_encoder RTL.
module flight_log_field_encoder_tb;
    import fle_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    fle_stream_if #(.T(req_t)) req (clk);
    fle_stream_if #(.T(rsp_t)) rsp (clk);

    flight_log_field_encoder dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Expected log bytes, oldest first
    rsp_t log_q[$];
    int   mismatches = 0;
    int   send_idle_pct = 25;
    int   recv_idle_pct = 49;
    int   hold_off_cycles = 0;
    int   stall_cycles = 0;
    bit   timed_out = 1'b0;
    bit   stim_done = 1'b0;

    // Predicted stream for one request
    logic [7:0] enc_bytes[$];

    function automatic logic [31:0] zz_of(logic [31:0] v);
        return {v[30:0], 1'b0} ^ {32{v[31]}};
    endfunction

    function automatic void put_varint(logic [31:0] v);
        while (v > 32'd127)
        begin
            enc_bytes.push_back({1'b1, v[6:0]});
            v = v >> 7;
        end
        enc_bytes.push_back(v[7:0]);
    endfunction

    function automatic void pack_tag2x3(req_t r);
        logic signed [31:0] s[3];
        logic [1:0] tag;
        logic [1:0] cls[3];
        tag = 2'd0;
        s[0] = r.value0;
        s[1] = r.value1;
        s[2] = r.value2;
        for (int x = 0; x < 3; x++)
        begin
            if (s[x] >= 32 || s[x] < -32) tag = 2'd3;
            else if (s[x] >= 8 || s[x] < -8) begin if (tag < 2) tag = 2'd2; end
            else if (s[x] >= 2 || s[x] < -2) begin if (tag < 1) tag = 2'd1; end
        end
        case (tag)
            2'd0: enc_bytes.push_back({2'b00, s[0][1:0], s[1][1:0], s[2][1:0]});
            2'd1:
            begin
                enc_bytes.push_back({4'b0100, s[0][3:0]});
                enc_bytes.push_back({s[1][3:0], s[2][3:0]});
            end
            2'd2:
            begin
                enc_bytes.push_back({2'b10, s[0][5:0]});
                enc_bytes.push_back(s[1][7:0]);
                enc_bytes.push_back(s[2][7:0]);
            end
            default:
            begin
                for (int x = 0; x < 3; x++)
                begin
                    if (s[x] < 128 && s[x] >= -128) cls[x] = 2'd0;
                    else if (s[x] < 32768 && s[x] >= -32768) cls[x] = 2'd1;
                    else if (s[x] < 8388608 && s[x] >= -8388608) cls[x] = 2'd2;
                    else cls[x] = 2'd3;
                end
                enc_bytes.push_back({2'b11, cls[2], cls[1], cls[0]});
                for (int x = 0; x < 3; x++)
                    for (int k = 0; k <= cls[x]; k++)
                        enc_bytes.push_back(s[x] >> (8 * k));
            end
        endcase
    endfunction

    function automatic void pack_tag8x4(req_t r);
        logic signed [31:0] s[4];
        logic [1:0] cls[4];
        logic [7:0] hold;
        bit half;
        hold = 8'h00;
        half = 1'b0;
        s[0] = r.value0;
        s[1] = r.value1;
        s[2] = r.value2;
        s[3] = r.value3;
        for (int x = 0; x < 4; x++)
        begin
            if (s[x] == 0) cls[x] = 2'd0;
            else if (s[x] < 8 && s[x] >= -8) cls[x] = 2'd1;
            else if (s[x] < 128 && s[x] >= -128) cls[x] = 2'd2;
            else cls[x] = 2'd3;
        end
        enc_bytes.push_back({cls[3], cls[2], cls[1], cls[0]});
        // Nibble stream, big-endian, carry half byte across fields
        for (int x = 0; x < 4; x++)
        begin
            case (cls[x])
                2'd1:
                    if (!half)
                    begin
                        hold = {s[x][3:0], 4'h0};
                        half = 1'b1;
                    end
                    else
                    begin
                        enc_bytes.push_back(hold | s[x][3:0]);
                        half = 1'b0;
                    end
                2'd2:
                    if (!half) enc_bytes.push_back(s[x][7:0]);
                    else
                    begin
                        enc_bytes.push_back(hold | s[x][7:4]);
                        hold = {s[x][3:0], 4'h0};
                    end
                2'd3:
                    if (!half)
                    begin
                        enc_bytes.push_back(s[x][15:8]);
                        enc_bytes.push_back(s[x][7:0]);
                    end
                    else
                    begin
                        enc_bytes.push_back(hold | s[x][15:12]);
                        enc_bytes.push_back(s[x][11:4]);
                        hold = {s[x][3:0], 4'h0};
                    end
                default: ;
            endcase
        end
        if (half) enc_bytes.push_back(hold);
    endfunction

    function automatic void pack_bitmap(req_t r);
        logic [31:0] v[8];
        int cnt;
        logic [7:0] hdr;
        v = '{r.value0, r.value1, r.value2, r.value3,
              r.value4, r.value5, r.value6, r.value7};
        cnt = (r.field_count > 8) ? 8 : r.field_count;
        hdr = 8'h00;
        if (cnt == 0) return;
        if (cnt == 1)
        begin
            put_varint(zz_of(v[0]));
            return;
        end
        for (int i = 0; i < cnt; i++)
            if (v[i] != 0) hdr[i] = 1'b1;
        enc_bytes.push_back(hdr);
        for (int i = 0; i < cnt; i++)
            if (v[i] != 0) put_varint(zz_of(v[i]));
    endfunction

    // Work out the log bytes of one request and queue them
    function automatic void predict_log_bytes(req_t r);
        rsp_t e;
        enc_bytes.delete();
        case (op_t'(r.operation))
            OP_UVARINT: put_varint(r.value0);
            OP_SVARINT: put_varint(zz_of(r.value0));
            OP_S16:
            begin
                enc_bytes.push_back(r.value0[7:0]);
                enc_bytes.push_back(r.value0[15:8]);
            end
            OP_U32:
                for (int k = 0; k < 4; k++) enc_bytes.push_back(r.value0 >> (8 * k));
            OP_TAG2X3: pack_tag2x3(r);
            OP_TAG8X4: pack_tag8x4(r);
            OP_BITMAP: pack_bitmap(r);
            default: ;
        endcase
        foreach (enc_bytes[i])
        begin
            e.out_byte = enc_bytes[i];
            e.last_byte = (i == enc_bytes.size() - 1);
            log_q.push_back(e);
        end
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 6))
            0: return 32'(int'($urandom_range(0, 4)) - 2);
            1: return 32'(int'($urandom_range(0, 16)) - 8);
            2: return 32'(int'($urandom_range(0, 256)) - 128);
            3: return 32'(int'($urandom_range(0, 65536)) - 32768);
            4: return 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
            5: return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    function automatic req_t rand_request();
        req_t r;
        r.operation = 3'($urandom_range(0, 7));
        r.value0 = rand_value();
        r.value1 = rand_value();
        r.value2 = rand_value();
        r.value3 = rand_value();
        r.value4 = rand_value();
        r.value5 = rand_value();
        r.value6 = rand_value();
        r.value7 = rand_value();
        r.field_count = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(2, 8));
        return r;
    endfunction

    // Directed rows: request plus first expected byte where obvious
    typedef struct {
        op_t         op;
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] v2;
        logic [31:0] v3;
        logic [3:0]  cnt;
        bit          known;
        logic [7:0]  first_byte;
    } row_t;

    row_t rows[] = '{
        '{OP_UVARINT, 32'h0, 0, 0, 0, 0, 1, 8'h00},
        '{OP_UVARINT, 32'hFFFF_FFFF, 0, 0, 0, 0, 1, 8'hFF},
        '{OP_UVARINT, 32'd127, 0, 0, 0, 0, 1, 8'h7F},
        '{OP_UVARINT, 32'd128, 0, 0, 0, 0, 1, 8'h80},
        '{OP_SVARINT, 32'hFFFF_FFFF, 0, 0, 0, 0, 1, 8'h01},
        '{OP_SVARINT, 32'h8000_0000, 0, 0, 0, 0, 1, 8'hFF},
        '{OP_SVARINT, 32'h7FFF_FFFF, 0, 0, 0, 0, 1, 8'hFE},
        '{OP_S16, 32'h1234_8001, 0, 0, 0, 0, 1, 8'h01},
        '{OP_U32, 32'hDEAD_BEEF, 0, 0, 0, 0, 1, 8'hEF},
        '{OP_TAG2X3, 32'h1, 32'hFFFF_FFFE, 32'h0, 0, 0, 1, 8'h18},
        '{OP_TAG2X3, 32'h7, 32'hFFFF_FFF8, 32'h2, 0, 0, 0, 8'h00},
        '{OP_TAG2X3, 32'd31, 32'hFFFF_FFE0, 32'h8, 0, 0, 0, 8'h00},
        '{OP_TAG2X3, 32'h8000_0000, 32'd32768, 32'h7FFF_FFFF, 0, 0, 0, 8'h00},
        '{OP_TAG2X3, 32'd128, 32'hFF80_0000, 32'hFFFF_FF80, 0, 0, 0, 8'h00},
        '{OP_TAG8X4, 32'h0, 32'h0, 32'h0, 32'h0, 0, 1, 8'h00},
        '{OP_TAG8X4, 32'h7, 32'hFFFF_FFF8, 32'h1, 32'h0, 0, 0, 8'h00},
        '{OP_TAG8X4, 32'h3, 32'd127, 32'h0001_2345, 32'h5, 0, 0, 8'h00},
        '{OP_TAG8X4, 32'h8000_0000, 32'hFFFF_FF80, 32'd128, 32'h1, 0, 0, 8'h00},
        '{OP_BITMAP, 32'h5, 32'h0, 32'h0, 32'h0, 4'd0, 0, 8'h00},
        '{OP_BITMAP, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 4'd1, 1, 8'h01},
        '{OP_BITMAP, 32'h0, 32'h1, 32'h8000_0000, 32'h0, 4'd8, 0, 8'h00},
        '{OP_BITMAP, 32'h7FFF_FFFF, 32'h1, 32'h0, 32'h3, 4'd15, 0, 8'h00},
        '{OP_NONE, 32'h1, 32'h1, 32'h1, 32'h1, 4'd8, 0, 8'h00}
    };

    // Offer one request and wait for its transfer; valid drops only when idling
    task automatic send_request(req_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.data <= r;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        predict_log_bytes(r);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (log_q.size() != 0) @(negedge clk);
        repeat (70) @(negedge clk);
    endtask

    // Stimulus
    initial
    begin
        req_t r;
        req.valid = 1'b0;
        req.data = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (rows[i])
        begin
            r = '0;
            r.operation = rows[i].op;
            r.value0 = rows[i].v0;
            r.value1 = rows[i].v1;
            r.value2 = rows[i].v2;
            r.value3 = rows[i].v3;
            r.value4 = (i % 2) ? 32'hFFFF_FFFF : 32'h0;
            r.value5 = 32'h8000_0000;
            r.value6 = (i % 3) ? 32'd1000 : 32'h0;
            r.value7 = 32'hFFFF_FFFF;
            r.field_count = rows[i].cnt;
            send_request(r);
            if (rows[i].known && log_q.size() != 0
                && log_q[log_q.size() - enc_bytes.size()].out_byte != rows[i].first_byte)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("row %0d: predicted first byte %h, table says %h",
                             i, log_q[log_q.size() - enc_bytes.size()].out_byte,
                             rows[i].first_byte);
            end
        end
        // Pause until every expected byte is back
        wait_drained();
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 49 : 0;
            recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 25 : 0;
            if (phase == 1) hold_off_cycles = 300;
            for (int n = 0; n < 83; n++) send_request(rand_request());
        end
        req.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls plus one long hold-off
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                rsp.ready <= 1'b0;
                hold_off_cycles--;
            end
            else
                rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check each transferred byte against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (log_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected byte %h last %b", rsp.data.out_byte,
                             rsp.data.last_byte);
            end
            else if (rsp.data !== log_q[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("byte mismatch: expected %h last %b, got %h last %b",
                             log_q[0].out_byte, log_q[0].last_byte,
                             rsp.data.out_byte, rsp.data.last_byte);
                void'(log_q.pop_front());
            end
            else
                void'(log_q.pop_front());
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 5000) timed_out <= 1'b1;
    end

    // End of run
    initial
    begin
        wait (stim_done || timed_out);
        while (log_q.size() != 0 && !timed_out) @(negedge clk);
        if (!timed_out) repeat (70) @(negedge clk);
        if (timed_out)
            $display("[FAIL] regression broken");
        else if (mismatches == 0 && log_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+src
src/fle_pkg.sv
src/fle_stream_if.sv
src/fle_class.sv
src/fle_byte_unit.sv
src/flight_log_field_encoder.sv
verif/flight_log_field_encoder_tb.sv
